[src/snfcs_pkg.sv]
// ----------------------------------------------------------------------------
// snfcs_pkg
// Shared types, command codes and helpers for the SPI NOR flash command
// sequencer.
// ----------------------------------------------------------------------------
package snfcs_pkg;

    // field widths
    localparam int unsigned ADDR_W      = 24;
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned OP_W        = 3;
    localparam int unsigned ACT_W       = 2;
    localparam int unsigned PAGE_BYTES  = 256;
    localparam int unsigned PAGE_W      = $clog2(PAGE_BYTES + 1);
    localparam int unsigned MAX_RESULTS = 9;
    localparam int unsigned IDX_W       = $clog2(MAX_RESULTS + 1);

    // host operation codes
    localparam logic [OP_W-1:0] OP_READ        = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE_START = 3'd1;
    localparam logic [OP_W-1:0] OP_WRITE_BYTE  = 3'd2;
    localparam logic [OP_W-1:0] OP_STATUS_BYTE = 3'd3;
    localparam logic [OP_W-1:0] OP_SECTOR_ERASE = 3'd4;
    localparam logic [OP_W-1:0] OP_CHIP_ERASE  = 3'd5;
    localparam logic [OP_W-1:0] OP_LINK_ERROR  = 3'd6;

    // spi byte actions
    localparam logic [ACT_W-1:0] ACT_SEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_RECV = 2'd1;
    localparam logic [ACT_W-1:0] ACT_END  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_DONE = 2'd3;

    // flash command bytes
    localparam logic [7:0] CMD_WREN = 8'h06;
    localparam logic [7:0] CMD_RDSR = 8'h05;
    localparam logic [7:0] CMD_READ = 8'h03;
    localparam logic [7:0] CMD_PP   = 8'h02;
    localparam logic [7:0] CMD_SE   = 8'h20;
    localparam logic [7:0] CMD_CE   = 8'hC7;
    localparam logic [7:0] BUSY_BIT = 8'h01;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_DATA = 2'd1,
        PH_POLL = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic [ADDR_W-1:0]   cursor_address;
        logic [CNT_W-1:0]    bytes_remaining;
        logic [PAGE_W-1:0]   page_bytes_left;
    } t_state;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [7:0]       tx_byte;
        logic [CNT_W-1:0] rx_count;
        logic             ok;
    } t_result;

    function automatic t_result mk_res(logic [ACT_W-1:0] act, logic [7:0] tx,
                                       logic [CNT_W-1:0] rx, logic ok);
        t_result r;
        r.action   = act;
        r.tx_byte  = tx;
        r.rx_count = rx;
        r.ok       = ok;
        return r;
    endfunction

    function automatic t_result mk_send(logic [7:0] tx);
        return mk_res(ACT_SEND, tx, '0, 1'b0);
    endfunction

    function automatic t_result mk_ctl(logic [ACT_W-1:0] act);
        return mk_res(act, 8'h00, '0, 1'b0);
    endfunction

endpackage

[src/snfcs_if.sv]
// ----------------------------------------------------------------------------
// snfcs_cmd_if / snfcs_act_if
// Valid/ready channels for host requests and spi byte actions.
// ----------------------------------------------------------------------------
interface snfcs_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [snfcs_pkg::OP_W-1:0]   op;
    logic [snfcs_pkg::ADDR_W-1:0] address;
    logic [snfcs_pkg::CNT_W-1:0]  byte_count;
    logic [7:0]                   data_byte;

    modport source (output valid, op, address, byte_count, data_byte, input ready);
    modport sink   (input valid, op, address, byte_count, data_byte, output ready);
endinterface

interface snfcs_act_if;
    logic                         valid;
    logic                         ready;
    logic [snfcs_pkg::ACT_W-1:0]  action;
    logic [7:0]                   tx_byte;
    logic [snfcs_pkg::CNT_W-1:0]  rx_count;
    logic                         ok;
    logic                         last;

    modport source (output valid, action, tx_byte, rx_count, ok, last, input ready);
    modport sink   (input valid, action, tx_byte, rx_count, ok, last, output ready);
endinterface

[src/snfcs_decode.sv]
// ----------------------------------------------------------------------------
// snfcs_decode
// Single-pass decode of one host request against the sequencer state:
// next state plus the full list of spi actions the request causes.
// ----------------------------------------------------------------------------
module snfcs_decode (
    input  logic [snfcs_pkg::OP_W-1:0]   i_op,
    input  logic [snfcs_pkg::ADDR_W-1:0] i_address,
    input  logic [snfcs_pkg::CNT_W-1:0]  i_byte_count,
    input  logic [7:0]                   i_data_byte,
    input  snfcs_pkg::t_state            i_state,
    output snfcs_pkg::t_state            o_state,
    output snfcs_pkg::t_result           o_list [snfcs_pkg::MAX_RESULTS],
    output logic [snfcs_pkg::IDX_W-1:0]  o_count
);
    import snfcs_pkg::*;

    logic              is_idle_start;
    logic [ADDR_W-1:0] pg_cursor;
    logic [CNT_W-1:0]  pg_remaining;
    logic [PAGE_W-1:0] pg_room;
    logic [PAGE_W-1:0] pg_len;
    t_result           pg_hdr [6];
    logic [PAGE_W-1:0] page_dec;
    logic [CNT_W-1:0]  rem_dec;

    // page start operands: new request in idle, stored cursor otherwise
    assign is_idle_start = (i_state.phase == PH_IDLE);
    assign pg_cursor     = is_idle_start ? i_address : i_state.cursor_address;
    assign pg_remaining  = is_idle_start ? i_byte_count : i_state.bytes_remaining;
    assign pg_room       = PAGE_W'(PAGE_BYTES) - PAGE_W'(pg_cursor % PAGE_BYTES);
    assign pg_len        = (pg_remaining < CNT_W'(pg_room)) ? PAGE_W'(pg_remaining)
                                                            : pg_room;

    // write-enable transaction then page-program header
    always_comb begin
        pg_hdr[0] = mk_send(CMD_WREN);
        pg_hdr[1] = mk_ctl(ACT_END);
        pg_hdr[2] = mk_send(CMD_PP);
        pg_hdr[3] = mk_send(pg_cursor[23:16]);
        pg_hdr[4] = mk_send(pg_cursor[15:8]);
        pg_hdr[5] = mk_send(pg_cursor[7:0]);
    end

    // saturating decrements for data bytes
    assign page_dec = (i_state.page_bytes_left != '0) ? i_state.page_bytes_left - 1'b1
                                                      : '0;
    assign rem_dec  = (i_state.bytes_remaining != '0) ? i_state.bytes_remaining - 1'b1
                                                      : '0;

    // request decode
    always_comb begin
        o_state = i_state;
        o_count = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            o_list[k] = mk_ctl(ACT_SEND);
        end

        unique case (i_state.phase)
            PH_IDLE: begin
                unique case (i_op)
                    OP_READ: begin
                        o_list[0] = mk_send(CMD_READ);
                        o_list[1] = mk_send(i_address[23:16]);
                        o_list[2] = mk_send(i_address[15:8]);
                        o_list[3] = mk_send(i_address[7:0]);
                        o_list[4] = mk_res(ACT_RECV, 8'h00, i_byte_count, 1'b0);
                        o_list[5] = mk_ctl(ACT_END);
                        o_list[6] = mk_res(ACT_DONE, 8'h00, '0, 1'b1);
                        o_count   = IDX_W'(7);
                    end
                    OP_WRITE_START: begin
                        o_state.cursor_address  = i_address;
                        o_state.bytes_remaining = i_byte_count;
                        if (i_byte_count == '0) begin
                            o_list[0] = mk_res(ACT_DONE, 8'h00, '0, 1'b1);
                            o_count   = IDX_W'(1);
                        end else begin
                            for (int k = 0; k < 6; k++) begin
                                o_list[k] = pg_hdr[k];
                            end
                            o_state.page_bytes_left = pg_len;
                            o_state.phase           = PH_DATA;
                            o_count                 = IDX_W'(6);
                        end
                    end
                    OP_SECTOR_ERASE: begin
                        o_list[0] = mk_send(CMD_WREN);
                        o_list[1] = mk_ctl(ACT_END);
                        o_list[2] = mk_send(CMD_SE);
                        o_list[3] = mk_send(i_address[23:16]);
                        o_list[4] = mk_send(i_address[15:8]);
                        o_list[5] = mk_send(i_address[7:0]);
                        o_list[6] = mk_ctl(ACT_END);
                        o_list[7] = mk_send(CMD_RDSR);
                        o_list[8] = mk_res(ACT_RECV, 8'h00, CNT_W'(1), 1'b0);
                        o_state.bytes_remaining = '0;
                        o_state.phase           = PH_POLL;
                        o_count                 = IDX_W'(9);
                    end
                    OP_CHIP_ERASE: begin
                        o_list[0] = mk_send(CMD_WREN);
                        o_list[1] = mk_ctl(ACT_END);
                        o_list[2] = mk_send(CMD_CE);
                        o_list[3] = mk_ctl(ACT_END);
                        o_list[4] = mk_send(CMD_RDSR);
                        o_list[5] = mk_res(ACT_RECV, 8'h00, CNT_W'(1), 1'b0);
                        o_state.bytes_remaining = '0;
                        o_state.phase           = PH_POLL;
                        o_count                 = IDX_W'(6);
                    end
                    default: ;
                endcase
            end
            PH_DATA, PH_POLL: begin
                if (i_op == OP_LINK_ERROR) begin
                    // abort: close the transaction and fail the request
                    o_list[0] = mk_ctl(ACT_END);
                    o_list[1] = mk_res(ACT_DONE, 8'h00, '0, 1'b0);
                    o_count   = IDX_W'(2);
                    o_state.phase           = PH_IDLE;
                    o_state.bytes_remaining = '0;
                    o_state.page_bytes_left = '0;
                end else if (i_state.phase == PH_DATA) begin
                    if (i_op == OP_WRITE_BYTE) begin
                        o_list[0] = mk_send(i_data_byte);
                        o_count   = IDX_W'(1);
                        o_state.cursor_address  = i_state.cursor_address + 1'b1;
                        o_state.bytes_remaining = rem_dec;
                        o_state.page_bytes_left = page_dec;
                        if (page_dec == '0) begin
                            // page complete: close and start polling
                            o_list[1]     = mk_ctl(ACT_END);
                            o_list[2]     = mk_send(CMD_RDSR);
                            o_list[3]     = mk_res(ACT_RECV, 8'h00, CNT_W'(1), 1'b0);
                            o_count       = IDX_W'(4);
                            o_state.phase = PH_POLL;
                        end
                    end
                end else begin
                    if (i_op == OP_STATUS_BYTE) begin
                        o_list[0] = mk_ctl(ACT_END);
                        if ((i_data_byte & BUSY_BIT) != 8'h00) begin
                            o_list[1] = mk_send(CMD_RDSR);
                            o_list[2] = mk_res(ACT_RECV, 8'h00, CNT_W'(1), 1'b0);
                            o_count   = IDX_W'(3);
                        end else if (i_state.bytes_remaining != '0) begin
                            // next page of the write
                            for (int k = 0; k < 6; k++) begin
                                o_list[k + 1] = pg_hdr[k];
                            end
                            o_state.page_bytes_left = pg_len;
                            o_state.phase           = PH_DATA;
                            o_count                 = IDX_W'(7);
                        end else begin
                            o_list[1] = mk_res(ACT_DONE, 8'h00, '0, 1'b1);
                            o_count   = IDX_W'(2);
                            o_state.phase           = PH_IDLE;
                            o_state.bytes_remaining = '0;
                            o_state.page_bytes_left = '0;
                        end
                    end
                end
            end
            default: begin
                o_state.phase           = PH_IDLE;
                o_state.bytes_remaining = '0;
                o_state.page_bytes_left = '0;
            end
        endcase
    end

endmodule

[src/spi_nor_flash_command_sequencer.sv]
// ----------------------------------------------------------------------------
// spi_nor_flash_command_sequencer
// Turns host flash requests into spi byte actions, splitting writes at page
// boundaries and polling the busy bit after programs and erases.
//
//   channel  dir  payload                                  handshake
//   i_cmd    in   op, address, byte_count, data_byte       valid/ready
//   o_act    out  action, tx_byte, rx_count, ok, last      valid/ready
//
// A request is decoded in its accept cycle into a list of up to nine actions
// held in a list register; the list drains one action per cycle into the
// output register while o_act is not stalled. The next request is taken in
// the cycle the last action of the current list moves to the output register.
// A stall on o_act holds the output register and the list. Reset is
// synchronous, active low, and returns the sequencer to idle with an empty
// list and no output.
// ----------------------------------------------------------------------------
module spi_nor_flash_command_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    snfcs_cmd_if.sink   i_cmd,
    snfcs_act_if.source o_act
);
    import snfcs_pkg::*;

    t_state             r_state;
    t_state             n_state;
    t_result            r_list [MAX_RESULTS];
    t_result            dec_list [MAX_RESULTS];
    logic [IDX_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   dec_cnt;
    logic [IDX_W-1:0]   r_idx;
    t_result            r_out;
    logic               r_out_valid;
    logic               r_out_last;
    logic               list_take;
    logic               list_final;
    logic               cmd_accept;

    snfcs_decode u_decode (
        .i_op         (i_cmd.op),
        .i_address    (i_cmd.address),
        .i_byte_count (i_cmd.byte_count),
        .i_data_byte  (i_cmd.data_byte),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_list       (dec_list),
        .o_count      (dec_cnt)
    );

    // list drain and request handshake
    assign list_take   = (r_cnt != '0) && (!r_out_valid || o_act.ready);
    assign list_final  = list_take && (r_idx == r_cnt - 1'b1);
    assign i_cmd.ready = (r_cnt == '0) || list_final;
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;

    // sequencer state and action list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= PH_IDLE;
            r_state.cursor_address  <= '0;
            r_state.bytes_remaining <= '0;
            r_state.page_bytes_left <= '0;
            r_cnt                   <= '0;
            r_idx                   <= '0;
        end else if (cmd_accept) begin
            r_state <= n_state;
            r_cnt   <= dec_cnt;
            r_idx   <= '0;
        end else if (list_final) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (list_take) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // list payload
    always_ff @(posedge i_clk) begin
        if (cmd_accept) begin
            r_list <= dec_list;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (list_take) begin
            r_out_valid <= 1'b1;
        end else if (o_act.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (list_take) begin
            r_out      <= r_list[r_idx];
            r_out_last <= (r_idx == r_cnt - 1'b1);
        end
    end

    assign o_act.valid    = r_out_valid;
    assign o_act.action   = r_out.action;
    assign o_act.tx_byte  = r_out.tx_byte;
    assign o_act.rx_count = r_out.rx_count;
    assign o_act.ok       = r_out.ok;
    assign o_act.last     = r_out_last;

endmodule

[src/snfcs_checker.sv]
// ----------------------------------------------------------------------------
// snfcs_checker
// Port-level checks on the spi action stream of the flash sequencer.
// ----------------------------------------------------------------------------
module snfcs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_act_valid,
    input logic                        i_act_ready,
    input logic [snfcs_pkg::ACT_W-1:0] i_action,
    input logic [7:0]                  i_tx_byte,
    input logic [snfcs_pkg::CNT_W-1:0] i_rx_count,
    input logic                        i_ok,
    input logic                        i_last
);
    import snfcs_pkg::*;

    // a stalled action stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_act_valid && !i_act_ready |=> i_act_valid)
        else $error("action dropped while stalled");

    // request done always closes the list of its request
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_act_valid && (i_action == ACT_DONE) |-> i_last)
        else $error("done action not marked last");

    // only send actions carry a byte
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_act_valid && (i_action != ACT_SEND) |-> (i_tx_byte == 8'h00))
        else $error("tx byte set on non-send action");

    // ok and rx count only on their own actions
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_act_valid |-> ((i_action == ACT_DONE) || !i_ok) &&
                        ((i_action == ACT_RECV) || (i_rx_count == '0)))
        else $error("ok or rx count set on wrong action");

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_act_valid (o_act.valid),
    .i_act_ready (o_act.ready),
    .i_action    (o_act.action),
    .i_tx_byte   (o_act.tx_byte),
    .i_rx_count  (o_act.rx_count),
    .i_ok        (o_act.ok),
    .i_last      (o_act.last)
);
